### rtl/vci_pkg.sv
// ---------------------------------------------------------------------------
// vci_pkg: shared types and constants for the voxel cell index block
// Field widths, register codes, reset values and pipeline control types.
// ---------------------------------------------------------------------------
package vci_pkg;

  // default cell count limit per axis
  localparam int AXIS_CELLS_MAX_DEF = 1024;

  // fixed field widths
  localparam int COORD_W = 32;
  localparam int ROW_W   = 48;
  localparam int COEF_W  = 16;
  localparam int INV_W   = 32;
  localparam int DIMS_W  = 33;
  localparam int DFLD_W  = 11;
  localparam int IDX_W   = 30;
  localparam int CFG_W   = 48;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ROW_W-1:0]          row_t;
  typedef logic [INV_W-1:0]          inv_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CFG_W-1:0]          cfg_data_t;

  // configuration register codes
  typedef enum logic [2:0] {
    REG_ROW_X    = 3'd0,
    REG_ROW_Y    = 3'd1,
    REG_ROW_Z    = 3'd2,
    REG_OFFSET_X = 3'd3,
    REG_OFFSET_Y = 3'd4,
    REG_OFFSET_Z = 3'd5,
    REG_INV_CELL = 3'd6,
    REG_GRID_DIM = 3'd7
  } reg_idx_t;

  // register reset values (identity map, unit cells, one cell per axis)
  localparam row_t       ROW_X_RST  = 48'h4000_0000_0000;
  localparam row_t       ROW_Y_RST  = 48'h0000_4000_0000;
  localparam row_t       ROW_Z_RST  = 48'h0000_0000_4000;
  localparam coord_t     OFFSET_RST = '0;
  localparam inv_t       INV_RST    = 32'h0001_0000;
  localparam logic [DIMS_W-1:0] DIMS_RST = 33'h0_0040_0801;

  // per-stage advance enables, shared by all datapath units
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

endpackage

### rtl/vci_if.sv
// ---------------------------------------------------------------------------
// vci_if: point and cell channels
// Valid/ready channels carrying input points and resulting cell indexes.
// ---------------------------------------------------------------------------
interface vci_point_if;
  import vci_pkg::*;

  logic   valid;
  logic   ready;
  coord_t coord_x;
  coord_t coord_y;
  coord_t coord_z;

  modport source (output valid, output coord_x, output coord_y, output coord_z,
                  input ready);
  modport sink (input valid, input coord_x, input coord_y, input coord_z,
                output ready);
endinterface

interface vci_cell_if;
  import vci_pkg::*;

  logic valid;
  logic ready;
  idx_t cell_index;
  logic inside_res;

  modport source (output valid, output cell_index, output inside_res, input ready);
  modport sink (input valid, input cell_index, input inside_res, output ready);
endinterface

### rtl/vci_axis.sv
// ---------------------------------------------------------------------------
// vci_axis: one axis of the affine map and cell quantizer
// Four stages: coefficient products, sum with offset, scale by inverse
// cell size, floor and range check.
// ---------------------------------------------------------------------------
module vci_axis #(
  parameter int  AXIS_CELLS_MAX = vci_pkg::AXIS_CELLS_MAX_DEF,
  localparam int CELL_W = (AXIS_CELLS_MAX > 1) ? $clog2(AXIS_CELLS_MAX) : 1,
  localparam int DIM_W  = $clog2(AXIS_CELLS_MAX + 1)
) (
  input  logic                clk,
  input  vci_pkg::stage_en_t  en,
  input  vci_pkg::coord_t     coord_x,
  input  vci_pkg::coord_t     coord_y,
  input  vci_pkg::coord_t     coord_z,
  input  vci_pkg::row_t       row,
  input  vci_pkg::coord_t     offset,
  input  vci_pkg::inv_t       inv,
  input  logic [DIM_W-1:0]    dim,
  output logic [CELL_W-1:0]   cell_idx,
  output logic                ok
);
  import vci_pkg::*;

  localparam int PROD_W = COEF_W + COORD_W;   // Q18.30 product
  localparam int FRAC_SH = 14;
  localparam int TERM_W = PROD_W - FRAC_SH;   // product floored to Q18.16
  localparam int T_W    = TERM_W + 2;         // sum of four terms
  localparam int UT_W   = T_W - 1;
  localparam int HALF_W = INV_W / 2;
  localparam int MUL_W  = UT_W + HALF_W;
  localparam int Q_W    = MUL_W + 1 - HALF_W;

  logic signed [COEF_W-1:0] coef0, coef1, coef2;
  logic signed [PROD_W-1:0] prod0, prod1, prod2;
  logic signed [T_W-1:0]    term0, term1, term2, off_ext;
  logic signed [T_W-1:0]    t;
  logic [UT_W-1:0]          ut;
  logic [MUL_W-1:0]         mul_hi, mul_lo;
  logic                     neg;
  logic [MUL_W:0]           scaled;
  logic [Q_W-1:0]           q;

  assign coef0 = row[ROW_W-1 -: COEF_W];
  assign coef1 = row[ROW_W-1-COEF_W -: COEF_W];
  assign coef2 = row[COEF_W-1:0];

  // stage 1: coefficient times coordinate
  always_ff @(posedge clk) begin
    if (en.s1) begin
      prod0 <= coef0 * coord_x;
      prod1 <= coef1 * coord_y;
      prod2 <= coef2 * coord_z;
    end
  end

  // floor each product to Q18.16 by arithmetic shift
  assign term0   = {{2{prod0[PROD_W-1]}}, prod0[PROD_W-1:FRAC_SH]};
  assign term1   = {{2{prod1[PROD_W-1]}}, prod1[PROD_W-1:FRAC_SH]};
  assign term2   = {{2{prod2[PROD_W-1]}}, prod2[PROD_W-1:FRAC_SH]};
  assign off_ext = {{(T_W-COORD_W){offset[COORD_W-1]}}, offset};

  // stage 2: transformed coordinate relative to grid minimum
  always_ff @(posedge clk) begin
    if (en.s2) begin
      t <= term0 + term1 + term2 + off_ext;
    end
  end

  assign ut = t[UT_W-1:0];

  // stage 3: split scale by the inverse cell size
  always_ff @(posedge clk) begin
    if (en.s3) begin
      neg    <= t[T_W-1];
      mul_hi <= {{HALF_W{1'b0}}, ut} * {{UT_W{1'b0}}, inv[INV_W-1:HALF_W]};
      mul_lo <= {{HALF_W{1'b0}}, ut} * {{UT_W{1'b0}}, inv[HALF_W-1:0]};
    end
  end

  assign scaled = {1'b0, mul_hi} + {{(HALF_W+1){1'b0}}, mul_lo[MUL_W-1:HALF_W]};
  assign q      = scaled[MUL_W:HALF_W];

  // stage 4: floor to cell and range check
  always_ff @(posedge clk) begin
    if (en.s4) begin
      ok       <= !neg && (q < Q_W'(dim));
      cell_idx <= q[CELL_W-1:0];
    end
  end

endmodule

### rtl/vci_linear.sv
// ---------------------------------------------------------------------------
// vci_linear: linear cell index
// Two stages forming x + nx*(y + ny*z), zero when any axis is outside.
// ---------------------------------------------------------------------------
module vci_linear #(
  parameter int  AXIS_CELLS_MAX = vci_pkg::AXIS_CELLS_MAX_DEF,
  localparam int CELL_W = (AXIS_CELLS_MAX > 1) ? $clog2(AXIS_CELLS_MAX) : 1,
  localparam int DIM_W  = $clog2(AXIS_CELLS_MAX + 1)
) (
  input  logic               clk,
  input  vci_pkg::stage_en_t en,
  input  logic [CELL_W-1:0]  cell_x,
  input  logic [CELL_W-1:0]  cell_y,
  input  logic [CELL_W-1:0]  cell_z,
  input  logic               ok_x,
  input  logic               ok_y,
  input  logic               ok_z,
  input  logic [DIM_W-1:0]   nx,
  input  logic [DIM_W-1:0]   ny,
  output vci_pkg::idx_t      cell_index,
  output logic               inside_res
);
  import vci_pkg::*;

  localparam int TMP_W = 2 * CELL_W;

  logic [DIM_W+CELL_W-1:0] prod_yz;
  logic [TMP_W-1:0]        tmp;
  logic [CELL_W-1:0]       ix;
  logic                    ok_all;
  logic [DIM_W+TMP_W-1:0]  prod_x;
  idx_t                    idx_next;

  assign prod_yz = ny * cell_z;

  // stage 5: y + ny*z
  always_ff @(posedge clk) begin
    if (en.s5) begin
      tmp    <= TMP_W'(prod_yz) + TMP_W'(cell_y);
      ix     <= cell_x;
      ok_all <= ok_x && ok_y && ok_z;
    end
  end

  assign prod_x   = nx * tmp;
  assign idx_next = IDX_W'(prod_x) + IDX_W'(ix);

  // stage 6: output register
  always_ff @(posedge clk) begin
    if (en.s6) begin
      cell_index <= ok_all ? idx_next : '0;
      inside_res <= ok_all;
    end
  end

endmodule

### rtl/voxel_cell_index.sv
// ---------------------------------------------------------------------------
// voxel_cell_index: point to voxel cell index
// Affine map of a Q16.16 point, scaling by inverse cell size, per-axis
// range check and linear cell index.
//
//   channel  dir  payload
//   pt       in   coord_x, coord_y, coord_z
//   vox      out  cell_index, inside_res
//   cfg      in   cfg_wr_en, cfg_index, cfg_data
//
// one point per cycle sustained while vox.ready is high; the six-stage pipeline
// is products, sum, scale, floor and two index steps
// rst clears every stage valid and returns the configuration registers to reset values
// a stage holds when the one after it is full and held; empty stages fill
// the last stage is the output register, so the input keeps flowing into
// empty stages while a result waits
// ---------------------------------------------------------------------------
module voxel_cell_index #(
  parameter int AXIS_CELLS_MAX = vci_pkg::AXIS_CELLS_MAX_DEF
) (
  input  logic                clk,
  input  logic                rst,
  vci_point_if.sink           pt,
  vci_cell_if.source          vox,
  input  logic                cfg_wr_en,
  input  vci_pkg::reg_idx_t   cfg_index,
  input  vci_pkg::cfg_data_t  cfg_data
);
  import vci_pkg::*;

  localparam int CELL_W = (AXIS_CELLS_MAX > 1) ? $clog2(AXIS_CELLS_MAX) : 1;
  localparam int DIM_W  = $clog2(AXIS_CELLS_MAX + 1);
  localparam logic [DFLD_W-1:0] DIM_SAT = DFLD_W'(AXIS_CELLS_MAX);

  row_t              row_x, row_y, row_z;
  coord_t            offset_x, offset_y, offset_z;
  inv_t              inv_cell_size;
  logic [DIMS_W-1:0] grid_dims;

  logic [DFLD_W-1:0] fld_x, fld_y, fld_z;
  logic [DIM_W-1:0]  nx, ny, nz;

  logic [5:0]        vld;
  stage_en_t         en;

  logic [CELL_W-1:0] cell_x, cell_y, cell_z;
  logic              ok_x, ok_y, ok_z;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_x         <= ROW_X_RST;
      row_y         <= ROW_Y_RST;
      row_z         <= ROW_Z_RST;
      offset_x      <= OFFSET_RST;
      offset_y      <= OFFSET_RST;
      offset_z      <= OFFSET_RST;
      inv_cell_size <= INV_RST;
      grid_dims     <= DIMS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ROW_X:    row_x         <= cfg_data[ROW_W-1:0];
        REG_ROW_Y:    row_y         <= cfg_data[ROW_W-1:0];
        REG_ROW_Z:    row_z         <= cfg_data[ROW_W-1:0];
        REG_OFFSET_X: offset_x      <= cfg_data[COORD_W-1:0];
        REG_OFFSET_Y: offset_y      <= cfg_data[COORD_W-1:0];
        REG_OFFSET_Z: offset_z      <= cfg_data[COORD_W-1:0];
        REG_INV_CELL: inv_cell_size <= cfg_data[INV_W-1:0];
        REG_GRID_DIM: grid_dims     <= cfg_data[DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate each dimension field to the axis limit
  assign fld_x = grid_dims[DFLD_W-1:0];
  assign fld_y = grid_dims[2*DFLD_W-1:DFLD_W];
  assign fld_z = grid_dims[3*DFLD_W-1:2*DFLD_W];
  assign nx = DIM_W'((fld_x > DIM_SAT) ? DIM_SAT : fld_x);
  assign ny = DIM_W'((fld_y > DIM_SAT) ? DIM_SAT : fld_y);
  assign nz = DIM_W'((fld_z > DIM_SAT) ? DIM_SAT : fld_z);

  // stage enables: a stage advances when empty or when the next one moves
  assign en.s6 = !vld[5] || vox.ready;
  assign en.s5 = !vld[4] || en.s6;
  assign en.s4 = !vld[3] || en.s5;
  assign en.s3 = !vld[2] || en.s4;
  assign en.s2 = !vld[1] || en.s3;
  assign en.s1 = !vld[0] || en.s2;

  assign pt.ready  = en.s1;
  assign vox.valid = vld[5];

  // stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en.s1) vld[0] <= pt.valid;
      if (en.s2) vld[1] <= vld[0];
      if (en.s3) vld[2] <= vld[1];
      if (en.s4) vld[3] <= vld[2];
      if (en.s5) vld[4] <= vld[3];
      if (en.s6) vld[5] <= vld[4];
    end
  end

  // per-axis map and quantize
  vci_axis #(.AXIS_CELLS_MAX(AXIS_CELLS_MAX)) u_axis_x (
    .clk(clk), .en(en),
    .coord_x(pt.coord_x), .coord_y(pt.coord_y), .coord_z(pt.coord_z),
    .row(row_x), .offset(offset_x), .inv(inv_cell_size), .dim(nx),
    .cell_idx(cell_x), .ok(ok_x)
  );

  vci_axis #(.AXIS_CELLS_MAX(AXIS_CELLS_MAX)) u_axis_y (
    .clk(clk), .en(en),
    .coord_x(pt.coord_x), .coord_y(pt.coord_y), .coord_z(pt.coord_z),
    .row(row_y), .offset(offset_y), .inv(inv_cell_size), .dim(ny),
    .cell_idx(cell_y), .ok(ok_y)
  );

  vci_axis #(.AXIS_CELLS_MAX(AXIS_CELLS_MAX)) u_axis_z (
    .clk(clk), .en(en),
    .coord_x(pt.coord_x), .coord_y(pt.coord_y), .coord_z(pt.coord_z),
    .row(row_z), .offset(offset_z), .inv(inv_cell_size), .dim(nz),
    .cell_idx(cell_z), .ok(ok_z)
  );

  // linear index and output register
  vci_linear #(.AXIS_CELLS_MAX(AXIS_CELLS_MAX)) u_linear (
    .clk(clk), .en(en),
    .cell_x(cell_x), .cell_y(cell_y), .cell_z(cell_z),
    .ok_x(ok_x), .ok_y(ok_y), .ok_z(ok_z),
    .nx(nx), .ny(ny),
    .cell_index(vox.cell_index), .inside_res(vox.inside_res)
  );

endmodule

### test/voxel_cell_index_tb.sv
// ---------------------------------------------------------------------------
// voxel_cell_index_tb: self-checking bench for the voxel cell index block
// Streams directed points and random bursts through the point channel under output
// stalls, predicts each cell index and inside flag from its own copy of the
// map registers, and checks every result beat in order.
// ---------------------------------------------------------------------------
module voxel_cell_index_tb;
  import vci_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 20;
  localparam int RAND_POINTS = 2000;

  // predictor and in-order checker for cell results
  class cell_index_checker;
    localparam int unsigned CELL_LIMIT = vci_pkg::AXIS_CELLS_MAX_DEF;

    typedef struct packed {
      idx_t index;
      logic in_grid;
    } cell_t;

    row_t        rows[3];
    coord_t      offs[3];
    inv_t        inv;
    logic [32:0] dims;
    cell_t       expected_cells[$];
    int unsigned errors;
    int unsigned n_points;
    int unsigned n_inside;

    function void reset_regs();
      rows[0] = ROW_X_RST;
      rows[1] = ROW_Y_RST;
      rows[2] = ROW_Z_RST;
      foreach (offs[a]) offs[a] = OFFSET_RST;
      inv  = INV_RST;
      dims = DIMS_RST;
    endfunction

    // registers keep only their own width of the written data
    function void write_reg(reg_idx_t r, cfg_data_t d);
      case (r)
        REG_ROW_X:    rows[0] = d[47:0];
        REG_ROW_Y:    rows[1] = d[47:0];
        REG_ROW_Z:    rows[2] = d[47:0];
        REG_OFFSET_X: offs[0] = d[31:0];
        REG_OFFSET_Y: offs[1] = d[31:0];
        REG_OFFSET_Z: offs[2] = d[31:0];
        REG_INV_CELL: inv     = d[31:0];
        REG_GRID_DIM: dims    = d[32:0];
        default: ;
      endcase
    endfunction

    // cells per axis, saturated at the axis limit
    function int unsigned dims_of(int a);
      logic [10:0] f;
      f = dims[11*a +: 11];
      return (f > CELL_LIMIT) ? CELL_LIMIT : int'(f);
    endfunction

    // transform one axis, scale and floor; 1 when the cell is in range
    function bit axis_cell(int a, coord_t pt[3], output int unsigned cell_o);
      longint            acc;
      logic signed [15:0] coef;
      logic [95:0]       scaled;
      acc    = longint'(offs[a]);
      cell_o = 0;
      for (int k = 0; k < 3; k++) begin
        coef = rows[a][47-16*k -: 16];
        acc += (longint'(coef) * longint'(pt[k])) >>> 14;
      end
      if (acc < 0) return 0;
      scaled = 96'(acc) * 96'(inv);
      if (scaled[95:32] >= dims_of(a)) return 0;
      cell_o = int'(scaled[95:32]);
      return 1;
    endfunction

    function void note_point(coord_t x, coord_t y, coord_t z);
      coord_t      pt[3];
      int unsigned c[3];
      bit          ok;
      cell_t       res;
      pt[0] = x;
      pt[1] = y;
      pt[2] = z;
      ok = 1;
      for (int a = 0; a < 3; a++) ok = axis_cell(a, pt, c[a]) && ok;
      if (ok) begin
        res.index   = idx_t'(longint'(c[0]) + longint'(dims_of(0)) *
                      (longint'(c[1]) + longint'(dims_of(1)) * longint'(c[2])));
        res.in_grid = 1'b1;
        n_inside++;
      end else begin
        res = '0;
      end
      expected_cells.push_back(res);
      n_points++;
    endfunction

    function void report(string what, longint exp_v, longint act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
    endfunction

    function void check_cell(idx_t index, logic in_grid);
      cell_t want;
      if (expected_cells.size() == 0) begin
        errors++;
        $display("%0t: result beat with no point pending, actual index %0h inside %0b",
                 $time, index, in_grid);
        return;
      end
      want = expected_cells.pop_front();
      if (index !== want.index) report("cell_index", want.index, index);
      if (in_grid !== want.in_grid) report("inside_res", want.in_grid, in_grid);
    endfunction

    function int unsigned pending();
      return expected_cells.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_wr_en;
  reg_idx_t  cfg_index;
  cfg_data_t cfg_data;

  vci_point_if pt_if ();
  vci_cell_if  cell_if ();

  cell_index_checker checker_h = new();
  bit          aimed_phase;
  int unsigned n_settings;

  voxel_cell_index #(
    .AXIS_CELLS_MAX(vci_pkg::AXIS_CELLS_MAX_DEF)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .pt        (pt_if),
    .vox       (cell_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD/2) clk = ~clk;

  // watch both channels at every edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cell_if.valid && cell_if.ready)
        checker_h.check_cell(cell_if.cell_index, cell_if.inside_res);
      if (pt_if.valid && pt_if.ready)
        checker_h.note_point(pt_if.coord_x, pt_if.coord_y, pt_if.coord_z);
    end
  end

  // result sink stalls in segments of differing character
  initial begin
    int unsigned mode;
    int unsigned seg;
    int unsigned cnt;
    cell_if.ready = 1'b0;
    cnt = 0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(16, 160);
      repeat (seg) begin
        @(posedge clk);
        case (mode)
          0: cell_if.ready <= 1'b1;
          1: cell_if.ready <= $urandom_range(0, 1);
          2: cell_if.ready <= ($urandom_range(0, 3) == 0);
          default: cell_if.ready <= (cnt[2:0] != 3'd0) && (cnt[2:0] != 3'd5);
        endcase
        cnt++;
      end
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic write_reg(reg_idx_t r, cfg_data_t d);
    cfg_wr_en <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    checker_h.write_reg(r, d);
    @(posedge clk);
  endtask

  // write every register, with junk above the width of each register narrower than the data
  task automatic configure(row_t rx, row_t ry, row_t rz, logic [31:0] ox,
                           logic [31:0] oy, logic [31:0] oz, inv_t ic,
                           logic [32:0] gd);
    write_reg(REG_ROW_X, rx);
    write_reg(REG_ROW_Y, ry);
    write_reg(REG_ROW_Z, rz);
    write_reg(REG_OFFSET_X, {16'($urandom), ox});
    write_reg(REG_OFFSET_Y, {16'($urandom), oy});
    write_reg(REG_OFFSET_Z, {16'($urandom), oz});
    write_reg(REG_INV_CELL, {16'($urandom), ic});
    write_reg(REG_GRID_DIM, {15'($urandom), gd});
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  // hold the beat until the block takes it
  task automatic send_point(coord_t x, coord_t y, coord_t z);
    pt_if.valid   <= 1'b1;
    pt_if.coord_x <= x;
    pt_if.coord_y <= y;
    pt_if.coord_z <= z;
    do @(posedge clk); while (!pt_if.ready);
  endtask

  // stop sending and let every pending result come out
  task automatic drain();
    pt_if.valid <= 1'b0;
    while (checker_h.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // mostly near-identity maps with grids that points can land in
  task automatic random_config();
    row_t        r[3];
    logic [31:0] o[3];
    inv_t        ic;
    logic [32:0] gd;
    logic [10:0] f;
    int unsigned pick;
    aimed_phase = ($urandom_range(0, 9) < 7);
    gd = '0;
    for (int a = 0; a < 3; a++) begin
      if (aimed_phase) begin
        pick = $urandom_range(0, 15);
        if (pick == 0) f = '0;
        else if (pick < 3) f = 11'($urandom_range(900, 2047));
        else f = 11'($urandom_range(1, 48));
        r[a] = '0;
        r[a][47-16*a -: 16] = 16'h4000;
        for (int k = 0; k < 3; k++)
          if (k != a && $urandom_range(0, 2) == 0)
            r[a][47-16*k -: 16] = 16'($urandom_range(0, 64)) - 16'd32;
        o[a] = 32'($urandom_range(0, 1 << 25)) - 32'(1 << 24);
      end else begin
        f    = 11'($urandom_range(0, 2047));
        r[a] = {16'($urandom), 32'($urandom)};
        o[a] = $urandom;
      end
      gd[11*a +: 11] = f;
    end
    ic = aimed_phase ? inv_t'($urandom_range(32'h4000, 32'h10_0000)) : inv_t'($urandom);
    configure(r[0], r[1], r[2], o[0], o[1], o[2], ic, gd);
  endtask

  // aim near the grid span on each axis, with some fully random points
  function automatic void random_point(output coord_t p[3]);
    longint      ext;
    longint      c;
    int unsigned n;
    bit          wild;
    wild = !aimed_phase || ($urandom_range(0, 4) == 0);
    for (int a = 0; a < 3; a++) begin
      if (wild) begin
        p[a] = $urandom;
      end else begin
        n   = checker_h.dims_of(a);
        ext = (n == 0) ? 64'sd1 << 20 : (longint'(n) << 32) / longint'(checker_h.inv);
        c   = ext * longint'($urandom_range(0, 1100)) / 1000 - ext / 20;
        c   = c - longint'(checker_h.offs[a]);
        if (c > 64'sh7FFF_FFFF) c = 64'sh7FFF_FFFF;
        if (c < -64'sh8000_0000) c = -64'sh8000_0000;
        p[a] = c[31:0];
      end
    end
  endfunction

  // bursts of random length with random gaps, some long unbroken runs
  task automatic run_random(int unsigned n);
    int unsigned burst;
    int unsigned gap;
    coord_t      p[3];
    burst = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (burst == 0) begin
        burst = ($urandom_range(0, 5) == 0) ? $urandom_range(64, 200) : $urandom_range(1, 24);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          pt_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      random_point(p);
      send_point(p[0], p[1], p[2]);
      burst--;
    end
    drain();
  endtask

  initial begin
    int unsigned done;
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_index     = REG_ROW_X;
    cfg_data      = '0;
    pt_if.valid   = 1'b0;
    pt_if.coord_x = '0;
    pt_if.coord_y = '0;
    pt_if.coord_z = '0;
    n_settings    = 0;
    checker_h.reset_regs();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset map: unit cells, one cell per axis
    send_point('0, '0, '0);
    send_point(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
    send_point(32'h0001_0000, '0, '0);
    send_point(32'hFFFF_FFFF, '0, '0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    drain();

    // oversized dimension fields saturate, top corner gives the largest index
    configure(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, '0, '0, '0, INV_RST, {3{11'h7FF}});
    send_point(32'h03FF_FFFF, 32'h03FF_FFFF, 32'h03FF_FFFF);
    send_point(32'h0400_0000, '0, '0);
    send_point('0, 32'h0400_0000, '0);
    send_point('0, '0, 32'h0400_0000);
    send_point(32'h0005_8000, 32'h0007_4000, 32'h0009_0000);
    drain();

    // zero cells on one axis puts every point outside
    configure(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, 32'h0001_0000, '0, '0, 32'hFFFF_FFFF,
              {11'd0, 11'd4, 11'd4});
    send_point('0, '0, '0);
    send_point(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    drain();

    // extreme coefficients and offsets, zero scale
    configure({16'h8000, 16'h7FFF, 16'h0001}, {16'h7FFF, 16'h8000, 16'hFFFF},
              {16'h0001, 16'hFFFF, 16'h8000}, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0,
              {11'd3, 11'd3, 11'd3});
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, '0);
    drain();

    // largest scale, tiny cells
    configure(ROW_X_RST, ROW_Y_RST, ROW_Z_RST, '0, '0, '0, 32'hFFFF_FFFF,
              {11'd1024, 11'd1024, 11'd1024});
    send_point('0, '0, '0);
    send_point(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    send_point(32'h0000_0002, 32'h0000_03FF, 32'h0000_0400);
    drain();

    // random settings, each followed by a run of points
    done = 0;
    while (done < RAND_POINTS) begin
      random_config();
      run_random($urandom_range(100, 250));
      done = checker_h.n_points - 20;
    end

    drain();
    repeat (12) @(posedge clk);
    if (checker_h.pending() != 0) begin
      checker_h.errors++;
      $display("%0t: %0d expected results never arrived", $time, checker_h.pending());
    end
    $display("%0d points across %0d register settings, %0d inside the grid",
             checker_h.n_points, n_settings + 1, checker_h.n_inside);
    $display("%0d mismatches", checker_h.errors);
    if (checker_h.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### sim.f
rtl/vci_pkg.sv
rtl/vci_if.sv
rtl/vci_axis.sv
rtl/vci_linear.sv
rtl/voxel_cell_index.sv
test/voxel_cell_index_tb.sv
